// ===== hw/rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, character codes and defaults of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // default screen geometry
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // field widths of the channels
    localparam int COLUMN_W   = 7;
    localparam int ROW_W      = 5;
    localparam int LINEAR_W   = 11;
    localparam int CELL_W     = 16;
    localparam int COLOR_W    = 4;
    localparam int CHAR_W     = 8;

    // item functions
    localparam logic FUNC_PUT = 1'b0;
    localparam logic FUNC_SET = 1'b1;

    // character codes
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI  = 8'h7F;

    // tab stop spacing and blank cell
    localparam int                TAB_STEP    = 8;
    localparam logic [CELL_W-1:0] BLANK_CELL  = 16'h0F20;
    localparam logic [COLOR_W-1:0] COLOR_RESET = 4'hF;

    // one command item
    typedef struct packed {
        logic                func;
        logic [CHAR_W-1:0]   char_code;
        logic [COLUMN_W-1:0] new_column;
        logic [ROW_W-1:0]    new_row;
    } tcw_item_t;

    // requests from the top level to the screen store
    typedef struct packed {
        logic scroll_start;
        logic char_we;
    } tcw_store_ctrl_t;

    // status from the screen store
    typedef struct packed {
        logic busy;
        logic clearing;
    } tcw_store_stat_t;

endpackage

// ===== hw/rtl/tcw_if.sv =====
// ----------------------------------------------------------------------------
// tcw channel interfaces
// Valid/ready channels for command items, results and the color register.
// ----------------------------------------------------------------------------
interface tcw_cmd_if;
    import tcw_pkg::*;
    logic                valid;
    logic                ready;
    logic                func;
    logic [CHAR_W-1:0]   char_code;
    logic [COLUMN_W-1:0] new_column;
    logic [ROW_W-1:0]    new_row;

    modport source (output valid, func, char_code, new_column, new_row, input ready);
    modport sink   (input valid, func, char_code, new_column, new_row, output ready);
endinterface

interface tcw_result_if;
    import tcw_pkg::*;
    logic                valid;
    logic                ready;
    logic [COLUMN_W-1:0] cursor_column;
    logic [ROW_W-1:0]    cursor_row;
    logic [LINEAR_W-1:0] cursor_position;
    logic                cell_written;
    logic [LINEAR_W-1:0] cell_address;
    logic [CELL_W-1:0]   cell_value;
    logic                scrolled;

    modport source (output valid, cursor_column, cursor_row, cursor_position, cell_written,
                    cell_address, cell_value, scrolled, input ready);
    modport sink   (input valid, cursor_column, cursor_row, cursor_position, cell_written,
                    cell_address, cell_value, scrolled, output ready);
endinterface

interface tcw_cfg_if;
    import tcw_pkg::*;
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] text_color;

    modport source (output valid, text_color, input ready);
    modport sink   (input valid, text_color, output ready);
endinterface

// ===== hw/rtl/tcw_cursor_unit.sv =====
// ----------------------------------------------------------------------------
// tcw_cursor_unit
// Cursor arithmetic for one item: motion, wrap, scroll detect, cell address.
// ----------------------------------------------------------------------------
module tcw_cursor_unit
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS,
    parameter int CW      = $clog2(COLUMNS) + 1,
    parameter int RW      = $clog2(ROWS) + 1,
    parameter int AW      = $clog2(COLUMNS * ROWS)
)
(
    input  tcw_item_t          item,
    input  logic [CW-1:0]      col_in,
    input  logic [RW-1:0]      line_in,
    input  logic [COLOR_W-1:0] color,
    output logic [CW-1:0]      col_out,
    output logic [RW-1:0]      line_out,
    output logic [AW-1:0]      position,
    output logic               we,
    output logic [AW-1:0]      waddr,
    output logic [CELL_W-1:0]  wdata,
    output logic               scroll
);

    logic [CW-1:0] col_t;
    logic [RW-1:0] line_t;
    logic [CW-1:0] wcol;

    // next cursor and cell write
    always_comb
    begin
        col_t  = col_in;
        line_t = line_in;
        wcol   = col_in;
        we     = 1'b0;
        wdata  = '0;
        scroll = 1'b0;
        if (item.func == FUNC_SET)
        begin
            if (int'(item.new_column) < COLUMNS)
                col_t = CW'(item.new_column);
            if (int'(item.new_row) < ROWS)
                line_t = RW'(item.new_row);
        end
        else
        begin
            case (item.char_code)
                CH_BACKSPACE:
                begin
                    if (col_in != '0)
                    begin
                        col_t = col_in - CW'(1);
                        wcol  = col_in - CW'(1);
                        we    = 1'b1;
                        wdata = {4'h0, color, CH_SPACE};
                    end
                end
                CH_TAB:
                begin
                    col_t = (col_in + CW'(TAB_STEP)) & ~CW'(TAB_STEP - 1);
                end
                CH_NEWLINE:
                begin
                    col_t  = '0;
                    line_t = line_in + RW'(1);
                end
                default:
                begin
                    if (item.char_code >= CH_SPACE && item.char_code <= CH_PRINT_HI)
                    begin
                        we    = 1'b1;
                        wdata = {4'h0, color, item.char_code};
                        col_t = col_in + CW'(1);
                    end
                end
            endcase
            // wrap to the next row
            if (col_t >= CW'(COLUMNS))
            begin
                col_t  = '0;
                line_t = line_t + RW'(1);
            end
            // past the last row: scroll up
            if (line_t >= RW'(ROWS))
            begin
                line_t = RW'(ROWS - 1);
                scroll = 1'b1;
            end
        end
    end

    assign col_out  = col_t;
    assign line_out = line_t;

    // linear indexes
    assign waddr    = AW'(AW'(line_in) * AW'(COLUMNS)) + AW'(wcol);
    assign position = AW'(AW'(line_t) * AW'(COLUMNS)) + AW'(col_t);

endmodule

// ===== hw/rtl/tcw_screen_store.sv =====
// ----------------------------------------------------------------------------
// tcw_screen_store
// Screen cell memory with a sweep engine for the reset clear and the scroll.
// ----------------------------------------------------------------------------
module tcw_screen_store
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS,
    parameter int AW      = $clog2(COLUMNS * ROWS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  tcw_store_ctrl_t   ctrl,
    input  logic [AW-1:0]     char_addr,
    input  logic [CELL_W-1:0] char_data,
    output tcw_store_stat_t   stat
);

    localparam int            CELLS    = COLUMNS * ROWS;
    localparam logic [AW-1:0] LAST     = AW'(CELLS - 1);
    localparam logic [AW-1:0] COPY_END = AW'(CELLS - COLUMNS);

    localparam logic [1:0] SW_IDLE  = 2'd0;
    localparam logic [1:0] SW_CLEAR = 2'd1;
    localparam logic [1:0] SW_COPY  = 2'd2;
    localparam logic [1:0] SW_FILL  = 2'd3;

    logic [CELL_W-1:0] mem [CELLS];

    logic [1:0]        state_reg, state_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic              cp_valid_reg;
    logic [AW-1:0]     cp_addr_reg;
    logic [CELL_W-1:0] rdata_reg;

    logic              rd_en;
    logic [AW-1:0]     raddr;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [CELL_W-1:0] wdata;

    // sweep sequencer
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        rd_en      = 1'b0;
        raddr      = idx_reg + AW'(COLUMNS);
        unique case (state_reg) inside
            SW_IDLE:
            begin
                if (ctrl.scroll_start)
                begin
                    state_next = SW_COPY;
                    idx_next   = '0;
                end
            end
            SW_CLEAR, SW_FILL:
            begin
                if (idx_reg == LAST)
                    state_next = SW_IDLE;
                else
                    idx_next = idx_reg + AW'(1);
            end
            SW_COPY:
            begin
                if (idx_reg == COPY_END)
                    state_next = SW_FILL;
                else
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = SW_IDLE;
            end
        endcase
    end

    // write port select: pending copy, blank sweep, then character write
    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg;
        wdata = BLANK_CELL;
        if (cp_valid_reg)
        begin
            we    = 1'b1;
            waddr = cp_addr_reg;
            wdata = rdata_reg;
        end
        else if (state_reg == SW_CLEAR || state_reg == SW_FILL)
        begin
            we = 1'b1;
        end
        else if (state_reg == SW_IDLE && ctrl.char_we)
        begin
            we    = 1'b1;
            waddr = char_addr;
            wdata = char_data;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= SW_CLEAR;
            idx_reg      <= '0;
            cp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            cp_valid_reg <= rd_en;
        end
    end

    // copy address is registered alongside the read data
    always_ff @(posedge clk)
    begin
        cp_addr_reg <= idx_reg;
    end

    // cell memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (rd_en)
            rdata_reg <= mem[raddr];
    end

    assign stat.busy     = (state_reg != SW_IDLE);
    assign stat.clearing = (state_reg == SW_CLEAR);

endmodule

// ===== hw/rtl/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Text screen writer: puts characters into a cell store and tracks the cursor.
// ----------------------------------------------------------------------------
// Usage
//   cmd    : one item per transfer; func 0 puts char_code, func 1 moves the
//            cursor to new_column/new_row (each taken only when in range).
//   result : one transfer per item with the cursor after the item, the cell
//            written (address and value, zero when none) and a scroll flag.
//   cfg    : writes text_color, the foreground nibble of written cells; always
//            ready; users write it only while no item is in flight; unchecked.
// Timing
//   An item is captured, then in ST_EXEC the cursor unit computes the move and
//   the cell write; the result register is loaded at commit, once it is free.
//   A scroll walks the whole store through the single write port, moving rows
//   up and blanking the last row; cmd is not ready again until it ends.
// Reset
//   The cursor goes to 0,0 and text_color to 15; the store is then cleared to
//   blank cells, one per cycle, with cmd not ready.
// Stall
//   A result waiting on result.ready holds; the next item can be taken, but
//   its result is not computed until the waiting one leaves.
// ----------------------------------------------------------------------------
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  logic            clk,
    input  logic            rst_n,
    tcw_cfg_if.sink         cfg,
    tcw_cmd_if.sink         cmd,
    tcw_result_if.source    result
);

    localparam int CW = $clog2(COLUMNS) + 1;
    localparam int RW = $clog2(ROWS) + 1;
    localparam int AW = $clog2(COLUMNS * ROWS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [CW-1:0]      col_reg;
    logic [RW-1:0]      line_reg;
    logic [COLOR_W-1:0] color_reg;
    tcw_item_t          item_reg;

    logic                out_valid_reg;
    logic [COLUMN_W-1:0] out_col_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic [LINEAR_W-1:0] out_pos_reg;
    logic                out_written_reg;
    logic [LINEAR_W-1:0] out_addr_reg;
    logic [CELL_W-1:0]   out_value_reg;
    logic                out_scrolled_reg;

    logic [CW-1:0]     col_calc;
    logic [RW-1:0]     line_calc;
    logic [AW-1:0]     pos_calc;
    logic              we_calc;
    logic [AW-1:0]     waddr_calc;
    logic [CELL_W-1:0] wdata_calc;
    logic              scroll_calc;

    logic              cmd_xfer;
    logic              out_free;
    logic              commit;
    tcw_store_ctrl_t   store_ctrl;
    tcw_store_stat_t   store_stat;

    // handshakes
    assign cmd.ready = (state_reg == ST_IDLE) && !store_stat.busy;
    assign cmd_xfer  = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;
    assign out_free  = !out_valid_reg || result.ready;
    assign commit    = (state_reg == ST_EXEC) && out_free;

    // cursor arithmetic
    tcw_cursor_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .CW      (CW),
        .RW      (RW),
        .AW      (AW)
    ) u_cursor (
        .item     (item_reg),
        .col_in   (col_reg),
        .line_in  (line_reg),
        .color    (color_reg),
        .col_out  (col_calc),
        .line_out (line_calc),
        .position (pos_calc),
        .we       (we_calc),
        .waddr    (waddr_calc),
        .wdata    (wdata_calc),
        .scroll   (scroll_calc)
    );

    // screen store
    assign store_ctrl.scroll_start = commit && scroll_calc;
    assign store_ctrl.char_we      = commit && we_calc;

    tcw_screen_store #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (store_ctrl),
        .char_addr (waddr_calc),
        .char_data (wdata_calc),
        .stat      (store_stat)
    );

    // item sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (commit)
                    state_next = scroll_calc ? ST_SWEEP : ST_IDLE;
            end
            ST_SWEEP:
            begin
                if (!store_stat.busy)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state, cursor and color
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            line_reg      <= '0;
            color_reg     <= COLOR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
                color_reg <= cfg.text_color;
            if (commit)
            begin
                col_reg  <= col_calc;
                line_reg <= line_calc;
            end
            if (commit)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // item capture and result register
    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            item_reg.func       <= cmd.func;
            item_reg.char_code  <= cmd.char_code;
            item_reg.new_column <= cmd.new_column;
            item_reg.new_row    <= cmd.new_row;
        end
        if (commit)
        begin
            out_col_reg      <= COLUMN_W'(col_calc);
            out_row_reg      <= ROW_W'(line_calc);
            out_pos_reg      <= LINEAR_W'(pos_calc);
            out_written_reg  <= we_calc;
            out_addr_reg     <= we_calc ? LINEAR_W'(waddr_calc) : '0;
            out_value_reg    <= we_calc ? wdata_calc : '0;
            out_scrolled_reg <= scroll_calc;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.cursor_column   = out_col_reg;
    assign result.cursor_row      = out_row_reg;
    assign result.cursor_position = out_pos_reg;
    assign result.cell_written    = out_written_reg;
    assign result.cell_address    = out_addr_reg;
    assign result.cell_value      = out_value_reg;
    assign result.scrolled        = out_scrolled_reg;

endmodule

// ===== hw/rtl/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks on the results of the text console writer.
// ----------------------------------------------------------------------------
module tcw_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic [COLUMN_W-1:0] cursor_column,
    input logic [ROW_W-1:0]    cursor_row,
    input logic                cell_written,
    input logic [LINEAR_W-1:0] cell_address,
    input logic [CELL_W-1:0]   cell_value,
    input logic                scrolled
);

    // cursor always on the screen
    a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> int'(cursor_column) < COLUMNS)
        else $error("cursor column beyond the screen");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> int'(cursor_row) < ROWS)
        else $error("cursor row beyond the screen");

    // no cell written: address and value read as zero
    a_idle_cell: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !cell_written |-> cell_address == '0 && cell_value == '0)
        else $error("cell fields set without a cell write");

    // a scroll leaves the cursor at the start of the last row
    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && scrolled |-> cursor_column == '0 &&
                                  cursor_row == ROW_W'(ROWS - 1))
        else $error("cursor not at start of last row after scroll");

    // written cells carry a background of zero
    a_background: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && cell_written |-> cell_value[CELL_W-1:CELL_W-4] == 4'h0)
        else $error("written cell has a nonzero background");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (result.valid),
    .cursor_column (result.cursor_column),
    .cursor_row    (result.cursor_row),
    .cell_written  (result.cell_written),
    .cell_address  (result.cell_address),
    .cell_value    (result.cell_value),
    .scrolled      (result.scrolled)
);
